>>> sv/sfc_pkg.sv
package sfc_pkg;

  localparam int unsigned NumCodes   = 3;
  localparam int unsigned CodeLen    = 4;
  localparam int unsigned DigitCount = 3;

  localparam logic [7:0] ChStart = 8'h7E;  // '~'
  localparam logic [7:0] ChEnd   = 8'h3B;  // ';'
  localparam logic [7:0] ChBar   = 8'h7C;  // '|'
  localparam logic [7:0] ChComma = 8'h2C;  // ','
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] CaseMask = 8'hDF;

  // known format codes, upper case, first letter in entry 0
  localparam logic [7:0] KnownCodes [NumCodes][CodeLen] = '{
    '{8'h4E, 8'h45, 8'h49, 8'h4C},
    '{8'h4E, 8'h55, 8'h4E, 8'h4F},
    '{8'h49, 8'h53, 8'h4D, 8'h41}
  };
  localparam logic [3:0] NeededFields [NumCodes] = '{4'd3, 4'd4, 4'd5};

  typedef enum logic [1:0] {
    StAccepted   = 2'd0,
    StMalformed  = 2'd1,
    StUnknown    = 2'd2,
    StFieldCount = 2'd3
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [1:0]  format_index;
    logic [3:0]  field_count;
    logic [7:0]  checksum_computed;
    logic [9:0]  checksum_given;
    logic        checksum_match;
  } result_t;

endpackage

>>> sv/sfc_parser.sv
module sfc_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic [7:0]      byte_i,
  output logic            result_valid_o,
  output sfc_pkg::result_t result_o
);
  import sfc_pkg::*;

  typedef enum logic [1:0] {
    PhSearch = 2'd0,
    PhCode   = 2'd1,
    PhData   = 2'd2,
    PhTail   = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  code_pos_q, code_pos_d;
  logic [7:0]  letters_q [CodeLen];
  logic        letter_we;
  logic        bad_q, bad_d;
  logic [7:0]  xor_q, xor_d;
  logic        parity_q, parity_d;
  logic [3:0]  commas_q, commas_d;
  logic        nonempty_q, nonempty_d;
  logic [1:0]  digits_q, digits_d;
  logic [9:0]  tail_q, tail_d;

  logic        is_letter, is_digit;
  logic        wellformed;
  logic [4:0]  fields_sum;
  logic [3:0]  fields;
  logic        found;
  logic [1:0]  found_idx;
  logic        code_eq [NumCodes];

  assign is_letter = byte_i inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign is_digit  = byte_i inside {[ChZero:ChNine]};

  always_comb begin
    phase_d    = phase_q;
    code_pos_d = code_pos_q;
    letter_we  = 1'b0;
    bad_d      = bad_q;
    xor_d      = xor_q;
    parity_d   = parity_q;
    commas_d   = commas_q;
    nonempty_d = nonempty_q;
    digits_d   = digits_q;
    tail_d     = tail_q;
    if (phase_q == PhSearch) begin
      if (byte_i == ChStart) begin
        phase_d    = PhCode;
        code_pos_d = '0;
        bad_d      = 1'b0;
        xor_d      = '0;
        parity_d   = 1'b0;
        commas_d   = '0;
        nonempty_d = 1'b0;
        digits_d   = '0;
        tail_d     = '0;
      end
    end else if (byte_i == ChEnd) begin
      phase_d = PhSearch;
    end else if (!bad_q) begin
      case (phase_q)
        PhCode: begin
          if (code_pos_q < 3'(CodeLen)) begin
            if (is_letter) begin
              letter_we  = 1'b1;
              code_pos_d = code_pos_q + 3'd1;
            end else begin
              bad_d = 1'b1;
            end
          end else if (byte_i == ChBar) begin
            phase_d = PhData;
          end else begin
            bad_d = 1'b1;
          end
        end
        PhData: begin
          if (byte_i == ChBar) begin
            phase_d = PhTail;
          end else if (byte_i == ChStart) begin
            bad_d = 1'b1;
          end else begin
            xor_d      = xor_q ^ byte_i;
            parity_d   = parity_q ^ byte_i[7];
            nonempty_d = 1'b1;
            if (byte_i == ChComma && commas_q != 4'hF) begin
              commas_d = commas_q + 4'd1;
            end
          end
        end
        default: begin
          if (is_digit && digits_q < 2'(DigitCount)) begin
            tail_d   = 10'(tail_q * 10'd10) + {6'd0, byte_i[3:0]};
            digits_d = digits_q + 2'd1;
          end else begin
            bad_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhSearch;
      code_pos_q <= '0;
      bad_q      <= 1'b0;
      xor_q      <= '0;
      parity_q   <= 1'b0;
      commas_q   <= '0;
      nonempty_q <= 1'b0;
      digits_q   <= '0;
      tail_q     <= '0;
    end else if (advance_i) begin
      phase_q    <= phase_d;
      code_pos_q <= code_pos_d;
      bad_q      <= bad_d;
      xor_q      <= xor_d;
      parity_q   <= parity_d;
      commas_q   <= commas_d;
      nonempty_q <= nonempty_d;
      digits_q   <= digits_d;
      tail_q     <= tail_d;
    end
  end

  // letters hold garbage until a full code is seen; matching checks code_pos
  always_ff @(posedge clk_i) begin
    if (advance_i && letter_we) begin
      letters_q[code_pos_q[1:0]] <= byte_i & CaseMask;
    end
  end

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int k = NumCodes - 1; k >= 0; k--) begin
      code_eq[k] = (letters_q[0] == KnownCodes[k][0]) && (letters_q[1] == KnownCodes[k][1])
                && (letters_q[2] == KnownCodes[k][2]) && (letters_q[3] == KnownCodes[k][3]);
      if (code_eq[k] && code_pos_q == 3'(CodeLen)) begin
        found     = 1'b1;
        found_idx = 2'(k);
      end
    end
  end

  assign wellformed = !bad_q && phase_q == PhTail && digits_q == 2'(DigitCount);
  assign fields_sum = {1'b0, commas_q} + 5'd1;
  assign fields     = !nonempty_q ? 4'd0 : (fields_sum[4] ? 4'hF : fields_sum[3:0]);

  always_comb begin
    result_o.format_index      = '0;
    result_o.field_count       = fields;
    result_o.checksum_computed = xor_q;
    result_o.checksum_given    = tail_q;
    result_o.checksum_match    = wellformed && !parity_q && tail_q == {2'd0, xor_q};
    if (!wellformed) begin
      result_o.status = StMalformed;
    end else if (!found) begin
      result_o.status = StUnknown;
    end else begin
      result_o.format_index = found_idx;
      result_o.status = (fields == NeededFields[found_idx]) ? StAccepted : StFieldCount;
    end
  end

  assign result_valid_o = phase_q != PhSearch && byte_i == ChEnd;

  // data and tail are only reached with a full code
  a_code_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData || phase_q == PhTail) |-> code_pos_q == 3'(CodeLen))
    else $error("data phase without full code");

  a_back_to_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && result_valid_o) |=> phase_q == PhSearch)
    else $error("sentence end did not return to search");

  a_match_wellformed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.checksum_match |-> result_o.status != StMalformed)
    else $error("checksum match on malformed sentence");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_pos_q <= 3'(CodeLen))
    else $error("code position overrun");

endmodule

>>> sv/sfc_out_reg.sv
module sfc_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  sfc_pkg::result_t data_i,
  input  logic             ready_i,
  output logic             valid_o,
  output logic             free_o,
  output sfc_pkg::result_t data_o
);
  import sfc_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/sentence_frame_checker_core.sv
// Sentence frame checker: byte stream in, one status item per sentence out.
// Input channel (in_valid_i/in_ready_o, byte_in_i) takes one stream byte per
// item. Bytes are discarded until '~'; the sentence then runs to the next
// ';', where one result item appears on the output channel (out_valid_o /
// out_ready_i) with status, format index, field count and checksums.
// Throughput: one byte per cycle, except that a sentence-closing ';' stalls
// while the result register is full. The closing ';' is parsed from the input
// register and loaded into the result register, which drives out_valid_o.
// When the receiver stalls with a result pending, bytes that produce no
// result keep flowing; a ';' that closes a sentence waits in the input
// register and in_ready_o stays low until the result register frees up.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to searching for a start byte.
module sentence_frame_checker_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [1:0] format_index_o,
  output logic [3:0] field_count_o,
  output logic [7:0] checksum_computed_o,
  output logic [9:0] checksum_given_o,
  output logic       checksum_match_o
);
  import sfc_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       advance;
  logic       res_valid;
  logic       out_free;
  result_t    res;
  result_t    out_data;

  assign advance    = in_valid_q && (!res_valid || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= byte_in_i;
    end
  end

  sfc_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .byte_i         (byte_q),
    .result_valid_o (res_valid),
    .result_o       (res)
  );

  sfc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_valid),
    .data_i  (res),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .free_o  (out_free),
    .data_o  (out_data)
  );

  assign status_o            = out_data.status;
  assign format_index_o      = out_data.format_index;
  assign field_count_o       = out_data.field_count;
  assign checksum_computed_o = out_data.checksum_computed;
  assign checksum_given_o    = out_data.checksum_given;
  assign checksum_match_o    = out_data.checksum_match;

endmodule
